[rtl/sbpc_pkg.sv]
package sbpc_pkg;

    localparam int DATA_W    = 16;
    localparam int ADDR_W    = 13;
    localparam int REG_W     = 3;
    localparam int NUM_REGS  = 8;
    localparam int MEM_WORDS = 8192;

    typedef enum logic [1:0] {
        CMD_WRITE_MEM = 2'd0,
        CMD_EXEC      = 2'd1,
        CMD_READ_REG  = 2'd2,
        CMD_READ_MEM  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RESP,
        S_FETCH,
        S_EXEC,
        S_LWB
    } t_state;

    localparam logic [2:0] OP_ALU  = 3'd0;
    localparam logic [2:0] OP_ADDI = 3'd1;
    localparam logic [2:0] OP_J    = 3'd2;
    localparam logic [2:0] OP_JAL  = 3'd3;
    localparam logic [2:0] OP_LW   = 3'd4;
    localparam logic [2:0] OP_SW   = 3'd5;
    localparam logic [2:0] OP_JEQ  = 3'd6;
    localparam logic [2:0] OP_SLTI = 3'd7;

    localparam logic [3:0] FN_ADD = 4'd0;
    localparam logic [3:0] FN_SUB = 4'd1;
    localparam logic [3:0] FN_OR  = 4'd2;
    localparam logic [3:0] FN_AND = 4'd3;
    localparam logic [3:0] FN_SLT = 4'd4;
    localparam logic [3:0] FN_JR  = 4'd8;

    localparam logic [REG_W-1:0] LINK_REG = 3'd7;

    typedef struct packed {
        logic              rf_we;
        logic [REG_W-1:0]  rf_waddr;
        logic [DATA_W-1:0] rf_wdata;
        logic              mem_we;
        logic              is_lw;
        logic [ADDR_W-1:0] mem_addr;
        logic [DATA_W-1:0] mem_wdata;
        logic [DATA_W-1:0] next_pc;
        logic              halt_set;
    } t_exec_res;

endpackage

[rtl/sbpc_if.sv]
interface sbpc_in_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      opcode;
    logic [sbpc_pkg::ADDR_W-1:0]     address;
    logic [sbpc_pkg::DATA_W-1:0]     word_data;

    modport source (output valid, opcode, address, word_data, input ready);
    modport sink   (input valid, opcode, address, word_data, output ready);
endinterface

interface sbpc_out_if;
    logic                            valid;
    logic                            ready;
    logic [sbpc_pkg::DATA_W-1:0]     read_data;
    logic [sbpc_pkg::DATA_W-1:0]     program_counter;
    logic                            halted;

    modport source (output valid, read_data, program_counter, halted, input ready);
    modport sink   (input valid, read_data, program_counter, halted, output ready);
endinterface

[rtl/sbpc_ram.sv]
module sbpc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/sbpc_exec.sv]
module sbpc_exec (
    input  logic [sbpc_pkg::DATA_W-1:0] i_instr,
    input  logic [sbpc_pkg::DATA_W-1:0] i_a,
    input  logic [sbpc_pkg::DATA_W-1:0] i_b,
    input  logic [sbpc_pkg::DATA_W-1:0] i_pc,
    output sbpc_pkg::t_exec_res         o_res
);

    always_comb begin
        logic [2:0]                  top;
        logic [sbpc_pkg::REG_W-1:0]  rb;
        logic [sbpc_pkg::REG_W-1:0]  rc;
        logic [sbpc_pkg::DATA_W-1:0] imm;
        logic [sbpc_pkg::ADDR_W-1:0] target;
        logic [sbpc_pkg::DATA_W-1:0] pc_inc;
        logic [sbpc_pkg::DATA_W-1:0] daddr;

        top    = i_instr[15:13];
        rb     = i_instr[9:7];
        rc     = i_instr[6:4];
        imm    = {{9{i_instr[6]}}, i_instr[6:0]};
        target = i_instr[12:0];
        pc_inc = i_pc + 16'd1;
        daddr  = i_a + imm;

        o_res           = '0;
        o_res.next_pc   = pc_inc;
        o_res.mem_addr  = daddr[sbpc_pkg::ADDR_W-1:0];
        o_res.mem_wdata = i_b;
        o_res.rf_waddr  = rb;

        case (top)
            sbpc_pkg::OP_ALU: begin
                o_res.rf_waddr = rc;
                case (i_instr[3:0])
                    sbpc_pkg::FN_ADD: begin
                        o_res.rf_we    = 1'b1;
                        o_res.rf_wdata = i_a + i_b;
                    end
                    sbpc_pkg::FN_SUB: begin
                        o_res.rf_we    = 1'b1;
                        o_res.rf_wdata = i_a - i_b;
                    end
                    sbpc_pkg::FN_OR: begin
                        o_res.rf_we    = 1'b1;
                        o_res.rf_wdata = i_a | i_b;
                    end
                    sbpc_pkg::FN_AND: begin
                        o_res.rf_we    = 1'b1;
                        o_res.rf_wdata = i_a & i_b;
                    end
                    sbpc_pkg::FN_SLT: begin
                        o_res.rf_we    = 1'b1;
                        o_res.rf_wdata = {15'd0, i_a < i_b};
                    end
                    sbpc_pkg::FN_JR: begin
                        if (i_instr[9:4] == 6'd0) begin
                            o_res.next_pc = i_a;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            sbpc_pkg::OP_ADDI: begin
                o_res.rf_we    = 1'b1;
                o_res.rf_wdata = daddr;
            end
            sbpc_pkg::OP_J: begin
                o_res.halt_set = (target == i_pc[sbpc_pkg::ADDR_W-1:0]);
                o_res.next_pc  = {3'd0, target};
            end
            sbpc_pkg::OP_JAL: begin
                o_res.rf_we    = 1'b1;
                o_res.rf_waddr = sbpc_pkg::LINK_REG;
                o_res.rf_wdata = pc_inc;
                o_res.next_pc  = {3'd0, target};
            end
            sbpc_pkg::OP_LW: begin
                o_res.rf_we = 1'b1;
                o_res.is_lw = 1'b1;
            end
            sbpc_pkg::OP_SW: begin
                o_res.mem_we = 1'b1;
            end
            sbpc_pkg::OP_JEQ: begin
                if (i_a == i_b) begin
                    o_res.next_pc = pc_inc + imm;
                end
            end
            default: begin
                o_res.rf_we    = 1'b1;
                o_res.rf_wdata = {15'd0, i_a < imm};
            end
        endcase

        // register 0 is never written
        if (o_res.rf_waddr == '0) begin
            o_res.rf_we = 1'b0;
        end
    end

endmodule

[rtl/sixteen_bit_processor_core.sv]
// sixteen-bit, eight-register processor core with one unified word memory
//
// i_cmd carries commands: write a memory word, execute one instruction,
// read a register (low three address bits) or read a memory word. o_res
// returns one item per command: read data (zero for write and execute),
// the program counter after the command and the halted flag.
//
// a read or write command gives its result through the response state and
// the output register, and a new command is taken every cycle while o_res
// is not stalled. execute takes fetch, register read and execute steps and
// takes the next command in its execute step; lw adds a data read step, and
// sw takes none in that step since the memory has a single write port. state
// lives in one synchronous memory and a duplicated register file with
// registered reads; same-cycle write/read pairs are forwarded.
//
// after reset the memory is zeroed by a sweep over every word with
// i_cmd.ready low. a stalled o_res holds its item; a command in progress
// then waits in its last step, and i_cmd.ready drops until it is taken.
// an execute while halted changes nothing. only reset clears halted.
module sixteen_bit_processor_core #(
    parameter int MEM_WORDS = sbpc_pkg::MEM_WORDS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sbpc_in_if.sink           i_cmd,
    sbpc_out_if.source        o_res
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam int DW = sbpc_pkg::DATA_W;
    localparam int RW = sbpc_pkg::REG_W;

    sbpc_pkg::t_state    r_state, n_state;
    sbpc_pkg::t_cmd      r_cmd, n_cmd;
    logic [AW-1:0]       r_clr, n_clr;
    logic [DW-1:0]       r_pc, n_pc;
    logic                r_halt, n_halt;
    logic [DW-1:0]       r_instr, n_instr;

    logic                r_out_valid, n_out_valid;
    logic [DW-1:0]       r_out_data, n_out_data;
    logic [DW-1:0]       r_out_pc, n_out_pc;
    logic                r_out_halt, n_out_halt;

    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [DW-1:0]       mem_wdata, mem_raw, mem_rd;
    logic                r_mfwd;
    logic [DW-1:0]       r_mfwd_data;

    logic                rf_we, rf_re;
    logic [RW-1:0]       rf_waddr, rfa_raddr, rfb_raddr;
    logic [DW-1:0]       rf_wdata, rfa_raw, rfb_raw, rf_a, rf_b;
    logic                r_afwd, r_bfwd, r_a_vld, r_b_vld;
    logic [DW-1:0]       r_afwd_data, r_bfwd_data;
    logic [sbpc_pkg::NUM_REGS-1:0] r_rf_vld;

    logic                slot_free, can_take, accept;
    sbpc_pkg::t_exec_res ex;

    sbpc_ram #(.WIDTH(DW), .DEPTH(MEM_WORDS)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_raw)
    );

    sbpc_ram #(.WIDTH(DW), .DEPTH(sbpc_pkg::NUM_REGS)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_re    (rf_re),
        .i_raddr (rfa_raddr),
        .o_rdata (rfa_raw)
    );

    sbpc_ram #(.WIDTH(DW), .DEPTH(sbpc_pkg::NUM_REGS)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_re    (rf_re),
        .i_raddr (rfb_raddr),
        .o_rdata (rfb_raw)
    );

    assign mem_rd = r_mfwd ? r_mfwd_data : mem_raw;
    assign rf_a   = r_afwd ? r_afwd_data : (r_a_vld ? rfa_raw : '0);
    assign rf_b   = r_bfwd ? r_bfwd_data : (r_b_vld ? rfb_raw : '0);

    sbpc_exec u_exec (
        .i_instr (r_instr),
        .i_a     (rf_a),
        .i_b     (rf_b),
        .i_pc    (r_pc),
        .o_res   (ex)
    );

    assign slot_free   = !r_out_valid || o_res.ready;
    assign i_cmd.ready = can_take;
    assign accept      = i_cmd.valid && can_take;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_clr       = r_clr;
        n_pc        = r_pc;
        n_halt      = r_halt;
        n_instr     = r_instr;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_data  = r_out_data;
        n_out_pc    = r_out_pc;
        n_out_halt  = r_out_halt;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        rf_we       = 1'b0;
        rf_waddr    = '0;
        rf_wdata    = '0;
        rf_re       = 1'b0;
        rfa_raddr   = '0;
        rfb_raddr   = '0;
        can_take    = 1'b0;

        case (r_state)
            sbpc_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + 1'b1;
                if (r_clr == AW'(MEM_WORDS - 1)) begin
                    n_state = sbpc_pkg::S_IDLE;
                end
            end
            sbpc_pkg::S_IDLE: begin
                can_take = 1'b1;
            end
            sbpc_pkg::S_RESP: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_pc    = r_pc;
                    n_out_halt  = r_halt;
                    case (r_cmd)
                        sbpc_pkg::CMD_READ_REG: n_out_data = rf_a;
                        sbpc_pkg::CMD_READ_MEM: n_out_data = mem_rd;
                        default:                n_out_data = '0;
                    endcase
                    n_state  = sbpc_pkg::S_IDLE;
                    can_take = 1'b1;
                end
            end
            sbpc_pkg::S_FETCH: begin
                n_instr   = mem_rd;
                rf_re     = 1'b1;
                rfa_raddr = mem_rd[12:10];
                rfb_raddr = mem_rd[9:7];
                n_state   = sbpc_pkg::S_EXEC;
            end
            sbpc_pkg::S_EXEC: begin
                if (ex.is_lw) begin
                    mem_re    = 1'b1;
                    mem_raddr = ex.mem_addr[AW-1:0];
                    n_state   = sbpc_pkg::S_LWB;
                end else if (slot_free) begin
                    rf_we       = ex.rf_we;
                    rf_waddr    = ex.rf_waddr;
                    rf_wdata    = ex.rf_wdata;
                    mem_we      = ex.mem_we;
                    mem_waddr   = ex.mem_addr[AW-1:0];
                    mem_wdata   = ex.mem_wdata;
                    n_pc        = ex.next_pc;
                    n_halt      = r_halt || ex.halt_set;
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    n_out_pc    = n_pc;
                    n_out_halt  = n_halt;
                    n_state     = sbpc_pkg::S_IDLE;
                    can_take    = !ex.mem_we;
                end
            end
            sbpc_pkg::S_LWB: begin
                if (slot_free) begin
                    rf_we       = ex.rf_we;
                    rf_waddr    = ex.rf_waddr;
                    rf_wdata    = mem_rd;
                    n_pc        = ex.next_pc;
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    n_out_pc    = n_pc;
                    n_out_halt  = r_halt;
                    n_state     = sbpc_pkg::S_IDLE;
                    can_take    = 1'b1;
                end
            end
            default: begin
                n_state = sbpc_pkg::S_IDLE;
            end
        endcase

        if (accept) begin
            n_cmd   = sbpc_pkg::t_cmd'(i_cmd.opcode);
            n_state = sbpc_pkg::S_RESP;
            case (sbpc_pkg::t_cmd'(i_cmd.opcode))
                sbpc_pkg::CMD_WRITE_MEM: begin
                    mem_we    = 1'b1;
                    mem_waddr = i_cmd.address[AW-1:0];
                    mem_wdata = i_cmd.word_data;
                end
                sbpc_pkg::CMD_EXEC: begin
                    if (!n_halt) begin
                        mem_re    = 1'b1;
                        mem_raddr = n_pc[AW-1:0];
                        n_state   = sbpc_pkg::S_FETCH;
                    end
                end
                sbpc_pkg::CMD_READ_REG: begin
                    rf_re     = 1'b1;
                    rfa_raddr = i_cmd.address[RW-1:0];
                end
                default: begin
                    mem_re    = 1'b1;
                    mem_raddr = i_cmd.address[AW-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sbpc_pkg::S_CLEAR;
            r_cmd       <= sbpc_pkg::CMD_WRITE_MEM;
            r_clr       <= '0;
            r_pc        <= '0;
            r_halt      <= 1'b0;
            r_out_valid <= 1'b0;
            r_rf_vld    <= '0;
            r_mfwd      <= 1'b0;
            r_afwd      <= 1'b0;
            r_bfwd      <= 1'b0;
            r_a_vld     <= 1'b0;
            r_b_vld     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmd       <= n_cmd;
            r_clr       <= n_clr;
            r_pc        <= n_pc;
            r_halt      <= n_halt;
            r_out_valid <= n_out_valid;
            if (rf_we) begin
                r_rf_vld[rf_waddr] <= 1'b1;
            end
            // a write in the cycle of a read to the same entry is forwarded
            if (mem_re) begin
                r_mfwd <= mem_we && (mem_waddr == mem_raddr);
            end
            if (rf_re) begin
                r_afwd  <= rf_we && (rf_waddr == rfa_raddr);
                r_bfwd  <= rf_we && (rf_waddr == rfb_raddr);
                r_a_vld <= r_rf_vld[rfa_raddr];
                r_b_vld <= r_rf_vld[rfb_raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_instr    <= n_instr;
        r_out_data <= n_out_data;
        r_out_pc   <= n_out_pc;
        r_out_halt <= n_out_halt;
        if (mem_re) begin
            r_mfwd_data <= mem_wdata;
        end
        if (rf_re) begin
            r_afwd_data <= rf_wdata;
            r_bfwd_data <= rf_wdata;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.read_data       = r_out_data;
    assign o_res.program_counter = r_out_pc;
    assign o_res.halted          = r_out_halt;

    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sbpc_pkg::S_CLEAR) |-> !i_cmd.ready)
        else $error("command taken during memory clear");

    a_one_mem_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd.opcode == sbpc_pkg::CMD_WRITE_MEM) |->
        !(r_state == sbpc_pkg::S_EXEC && ex.mem_we && !ex.is_lw))
        else $error("two memory writes in one cycle");

    a_no_result_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> (r_out_pc == $past(r_out_pc)) &&
        (r_out_data == $past(r_out_data)))
        else $error("held result overwritten");

    a_no_reg0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_we |-> (rf_waddr != '0))
        else $error("register 0 written");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halted cleared without reset");

endmodule
